// ===== hw/rtl/pgt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

    // defaults of the structural parameters
    localparam int GESTURE_SLOTS_DEF = 10;
    localparam int AVG_FRAC_BITS_DEF = 8;

    // fixed timing constants, in milliseconds
    localparam logic [31:0] HELLO_GAP = 32'd5000;
    localparam logic [31:0] QUIET_MS  = 32'd300;

    localparam int PCT_MAX = 100;

    // power stage codes of the input
    localparam logic [1:0] STAGE_AWAKE = 2'd0;
    localparam logic [1:0] STAGE_NAP   = 2'd1;
    localparam logic [1:0] STAGE_DEEP  = 2'd2;

    typedef enum logic [1:0] {
        MODE_SEEK  = 2'd0,
        MODE_DANCE = 2'd1,
        MODE_HOME  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CFG_EMA_PERCENT  = 3'd0,
        CFG_ON_THRESHOLD = 3'd1,
        CFG_OFF_THRESHOLD = 3'd2,
        CFG_LEVEL2_THRESHOLD = 3'd3,
        CFG_LEVEL3_THRESHOLD = 3'd4,
        CFG_LEVEL_HYSTERESIS = 3'd5,
        CFG_HOLD_MS      = 3'd6,
        CFG_COOLDOWN_MS  = 3'd7
    } cfg_index_t;

    // register reset values
    localparam logic [6:0]  EMA_PERCENT_RESET      = 7'd30;
    localparam logic [7:0]  ON_THRESHOLD_RESET     = 8'd60;
    localparam logic [7:0]  OFF_THRESHOLD_RESET    = 8'd40;
    localparam logic [7:0]  LEVEL2_THRESHOLD_RESET = 8'd100;
    localparam logic [7:0]  LEVEL3_THRESHOLD_RESET = 8'd170;
    localparam logic [7:0]  LEVEL_HYST_RESET       = 8'd10;
    localparam logic [15:0] HOLD_MS_RESET          = 16'd1500;
    localparam logic [15:0] COOLDOWN_MS_RESET      = 16'd400;

    typedef longint unsigned factor_tab_t [128];

    // ceil(min(p,100) * 2^shift / 100) for every 7-bit percent code, built at elaboration
    function automatic factor_tab_t build_factor_tab(int shift);
        factor_tab_t tab;
        longint unsigned pct;
        for (int i = 0; i < 128; i++)
        begin
            pct = (i > PCT_MAX) ? longint'(PCT_MAX) : longint'(i);
            tab[i] = ((pct << shift) + longint'(PCT_MAX - 1)) / PCT_MAX;
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/presence_gesture_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Presence and gesture tracker, one sensor frame per transaction.
// s_* carries frames in, m_* carries one result per frame out; cfg_we,
// cfg_index and cfg_data write the eight tuning registers. The user must
// write them only while idle; the block itself does not enforce this. A
// frame is taken into an input register; the moving average, presence and
// level hysteresis, mode machine and gesture cooldown are then evaluated in
// one pass and the result is loaded into the output register as soon as it
// is empty or being read. Throughput is one frame per cycle while m_tready is
// high; the average update (one multiply by a precomputed percent factor)
// is the loop that sets it. On a stall the result holds in the output
// register, one more frame waits in the input register and s_tready drops.
// Reset clears all tracking state (seek mode, no average, level one, all
// timers zero) and loads the register defaults; no clearing pass is needed.
module presence_gesture_tracker #(
    parameter int GESTURE_SLOTS = pgt_pkg::GESTURE_SLOTS_DEF,
    parameter int AVG_FRAC_BITS = pgt_pkg::AVG_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // delta_ms[9:0], stage[11:10], reading_ok[12], brightness[20:13],
    // gesture_ok[21], gesture_code[25:22], home_done[26], zero fill
    input  wire logic [31:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // mode[1:0], present[2], level[4:3], greet[5], tumble[9:6], goodbye[10],
    // level_tone[12:11], wake_request[13], activity[14], zero fill
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AvgW    = 8 + AVG_FRAC_BITS;
    localparam int ShiftW  = AVG_FRAC_BITS + 15;
    localparam int FactorW = ShiftW + 1;
    localparam int ProdW   = AvgW + FactorW;
    localparam int SlotW   = (GESTURE_SLOTS > 1) ? $clog2(GESTURE_SLOTS) : 1;
    localparam int InW     = 27;
    localparam int OutW    = 15;

    localparam pgt_pkg::factor_tab_t FactorTab = pgt_pkg::build_factor_tab(ShiftW);
    localparam logic [ProdW-1:0] RoundHalf = {{(ProdW-1){1'b0}}, 1'b1} << (ShiftW - 1);

    // configuration
    logic [FactorW-1:0] factor_reg;
    logic [7:0]         on_thr_reg;
    logic [7:0]         off_thr_reg;
    logic [7:0]         lvl2_thr_reg;
    logic [7:0]         lvl3_thr_reg;
    logic [7:0]         lvl_hyst_reg;
    logic [15:0]        hold_ms_reg;
    logic [15:0]        cooldown_ms_reg;

    // handshake stages
    logic               in_valid_reg;
    logic [InW-1:0]     in_data_reg;
    logic               out_valid_reg;
    logic [OutW-1:0]    out_data_reg;
    logic [OutW-1:0]    out_data_next;
    logic               advance;

    // tracking state
    pgt_pkg::mode_t     mode_reg, mode_next;
    logic [1:0]         last_stage_reg;
    logic [AvgW-1:0]    average_reg, average_next;
    logic               average_valid_reg, average_valid_next;
    logic               present_reg, present_next;
    logic [1:0]         level_reg, level_next;
    logic               ever_seen_reg, ever_seen_next;
    logic [31:0]        lost_since_reg, lost_since_next;
    logic [31:0]        now_ms_reg, now_ms_next;
    logic [31:0]        quiet_until_reg, quiet_until_next;
    logic [31:0]        last_tumble_reg [GESTURE_SLOTS];

    // frame fields
    logic [9:0]         delta_ms;
    logic [1:0]         stage_raw;
    logic               reading_ok;
    logic [7:0]         brightness;
    logic               gesture_ok;
    logic [3:0]         gesture_code;
    logic               home_done;

    assign delta_ms     = in_data_reg[9:0];
    assign stage_raw    = in_data_reg[11:10];
    assign reading_ok   = in_data_reg[12];
    assign brightness   = in_data_reg[20:13];
    assign gesture_ok   = in_data_reg[21];
    assign gesture_code = in_data_reg[25:22];
    assign home_done    = in_data_reg[26];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    // frame evaluation
    logic [1:0]         stage_eff;
    logic               awake;
    logic               deep_exit;
    logic               wake_entry;
    pgt_pkg::mode_t     mode_base;
    pgt_pkg::mode_t     mode_mid;
    logic               present_base;
    logic               valid_base;
    logic [1:0]         level_base;
    logic               run;
    logic [3:0]         code_eff;
    logic [AvgW-1:0]    target;
    logic               d_neg;
    logic [AvgW-1:0]    d_abs;
    logic [ProdW-1:0]   prod;
    logic [ProdW-1:0]   rsum;
    logic [AvgW-1:0]    step_q;
    logic [AvgW-1:0]    ema_avg;
    logic               avg_upd;
    logic               present_calc;
    logic               fall;
    logic [31:0]        since_lost;
    logic               hello_ok;
    logic               hold_ok;
    logic               ge3;
    logic               ge2;
    logic [8:0]         hold3_thr;
    logic [8:0]         hold2_thr;
    logic               hold3;
    logic               hold2;
    logic [1:0]         level_pick;
    logic               slot_ok;
    logic [SlotW-1:0]   slot_idx;
    logic [31:0]        since_tumble;
    logic               cool_ok;
    logic               gest_en;
    logic               take;
    logic               greet;
    logic [3:0]         tumble;
    logic               goodbye;
    logic [1:0]         level_tone;
    logic               wake_request;
    logic               activity;

    always_comb
    begin
        stage_eff  = (stage_raw > pgt_pkg::STAGE_DEEP) ? pgt_pkg::STAGE_DEEP : stage_raw;
        awake      = (stage_eff == pgt_pkg::STAGE_AWAKE);
        now_ms_next = now_ms_reg + {22'd0, delta_ms};
        deep_exit  = (last_stage_reg == pgt_pkg::STAGE_DEEP) && (stage_eff != pgt_pkg::STAGE_DEEP);
        wake_entry = (last_stage_reg != pgt_pkg::STAGE_AWAKE) && awake;

        mode_base    = (deep_exit || wake_entry) ? pgt_pkg::MODE_SEEK : mode_reg;
        present_base = (deep_exit || wake_entry) ? 1'b0 : present_reg;
        valid_base   = (deep_exit || wake_entry) ? 1'b0 : average_valid_reg;
        level_base   = deep_exit ? 2'd1 : level_reg;

        run      = (stage_eff != pgt_pkg::STAGE_DEEP) && (reading_ok || gesture_ok);
        code_eff = gesture_ok ? gesture_code : 4'd0;

        // average += round(d * pct / 100), with the factor ceil(pct * 2^s / 100)
        target  = {brightness, {AVG_FRAC_BITS{1'b0}}};
        d_neg   = target < average_reg;
        d_abs   = d_neg ? (average_reg - target) : (target - average_reg);
        prod    = ProdW'(d_abs) * ProdW'(factor_reg);
        rsum    = prod + RoundHalf;
        step_q  = rsum[ShiftW +: AvgW];
        ema_avg = d_neg ? (average_reg - step_q) : (average_reg + step_q);

        avg_upd      = run && reading_ok;
        average_next = average_reg;
        average_valid_next = valid_base;
        if (avg_upd)
        begin
            average_next = valid_base ? ema_avg : target;
            average_valid_next = 1'b1;
        end

        if (!present_base && (average_next >= {on_thr_reg, {AVG_FRAC_BITS{1'b0}}}))
            present_calc = 1'b1;
        else if (present_base && (average_next <= {off_thr_reg, {AVG_FRAC_BITS{1'b0}}}))
            present_calc = 1'b0;
        else
            present_calc = present_base;

        fall       = present_base && !present_calc;
        since_lost = now_ms_next - lost_since_reg;
        hello_ok   = since_lost >= pgt_pkg::HELLO_GAP;
        // a fresh loss restarts the absence timer at zero
        hold_ok    = fall ? (hold_ms_reg == 16'd0) : (since_lost >= {16'd0, hold_ms_reg});

        // level bands with sticky margin; a hold threshold below zero always holds
        ge3       = average_next >= {lvl3_thr_reg, {AVG_FRAC_BITS{1'b0}}};
        ge2       = average_next >= {lvl2_thr_reg, {AVG_FRAC_BITS{1'b0}}};
        hold3_thr = {1'b0, lvl3_thr_reg} - {1'b0, lvl_hyst_reg};
        hold2_thr = {1'b0, lvl2_thr_reg} - {1'b0, lvl_hyst_reg};
        hold3     = hold3_thr[8] || (average_next >= {hold3_thr[7:0], {AVG_FRAC_BITS{1'b0}}});
        hold2     = hold2_thr[8] || (average_next >= {hold2_thr[7:0], {AVG_FRAC_BITS{1'b0}}});
        level_pick = ge3 ? 2'd3 : (ge2 ? 2'd2 : 2'd1);
        if (level_base == 2'd3 && level_pick != 2'd3 && hold3)
            level_pick = 2'd3;
        if (level_base >= 2'd2 && level_pick == 2'd1 && hold2)
            level_pick = 2'd2;
        if (!present_calc)
            level_pick = 2'd1;

        slot_ok      = (code_eff != 4'd0) && ({1'b0, code_eff} < 5'(GESTURE_SLOTS));
        slot_idx     = code_eff[SlotW-1:0];
        since_tumble = now_ms_next - last_tumble_reg[slot_idx];
        cool_ok      = since_tumble >= {16'd0, cooldown_ms_reg};

        present_next    = present_base;
        lost_since_next = lost_since_reg;
        ever_seen_next  = ever_seen_reg;
        mode_mid        = mode_base;
        level_next      = level_base;
        greet           = 1'b0;
        goodbye         = 1'b0;
        level_tone      = 2'd0;
        wake_request    = 1'b0;
        activity        = 1'b0;
        gest_en         = 1'b0;

        if (run)
        begin
            if (!reading_ok)
            begin
                gest_en = awake && (mode_base == pgt_pkg::MODE_DANCE);
            end
            else
            begin
                present_next = present_calc;
                activity     = present_calc;
                wake_request = present_calc && !awake;
                if (awake)
                begin
                    if (fall)
                        lost_since_next = now_ms_next;
                    if (!present_base && present_calc)
                    begin
                        greet          = !ever_seen_reg || hello_ok;
                        ever_seen_next = 1'b1;
                        mode_mid       = pgt_pkg::MODE_DANCE;
                    end
                    if (mode_mid == pgt_pkg::MODE_DANCE)
                    begin
                        if (level_pick != level_base)
                        begin
                            level_next = level_pick;
                            if (now_ms_next >= quiet_until_reg)
                                level_tone = level_pick;
                        end
                        if (!present_calc && hold_ok)
                        begin
                            goodbye  = 1'b1;
                            mode_mid = pgt_pkg::MODE_HOME;
                        end
                        else
                        begin
                            gest_en = 1'b1;
                        end
                    end
                end
            end
        end

        take             = gest_en && slot_ok && cool_ok;
        tumble           = take ? code_eff : 4'd0;
        quiet_until_next = take ? (now_ms_next + pgt_pkg::QUIET_MS) : quiet_until_reg;
        if (take)
            activity = 1'b1;

        if (awake && (mode_mid == pgt_pkg::MODE_HOME) && home_done)
            mode_next = pgt_pkg::MODE_SEEK;
        else
            mode_next = mode_mid;

        out_data_next = {activity, wake_request, level_tone, goodbye, tumble, greet,
                         level_next, present_next, mode_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg      <= FactorTab[pgt_pkg::EMA_PERCENT_RESET][FactorW-1:0];
            on_thr_reg      <= pgt_pkg::ON_THRESHOLD_RESET;
            off_thr_reg     <= pgt_pkg::OFF_THRESHOLD_RESET;
            lvl2_thr_reg    <= pgt_pkg::LEVEL2_THRESHOLD_RESET;
            lvl3_thr_reg    <= pgt_pkg::LEVEL3_THRESHOLD_RESET;
            lvl_hyst_reg    <= pgt_pkg::LEVEL_HYST_RESET;
            hold_ms_reg     <= pgt_pkg::HOLD_MS_RESET;
            cooldown_ms_reg <= pgt_pkg::COOLDOWN_MS_RESET;
        end
        else if (cfg_we)
        begin
            case (pgt_pkg::cfg_index_t'(cfg_index))
                pgt_pkg::CFG_EMA_PERCENT:      factor_reg <= FactorTab[cfg_data[6:0]][FactorW-1:0];
                pgt_pkg::CFG_ON_THRESHOLD:     on_thr_reg <= cfg_data[7:0];
                pgt_pkg::CFG_OFF_THRESHOLD:    off_thr_reg <= cfg_data[7:0];
                pgt_pkg::CFG_LEVEL2_THRESHOLD: lvl2_thr_reg <= cfg_data[7:0];
                pgt_pkg::CFG_LEVEL3_THRESHOLD: lvl3_thr_reg <= cfg_data[7:0];
                pgt_pkg::CFG_LEVEL_HYSTERESIS: lvl_hyst_reg <= cfg_data[7:0];
                pgt_pkg::CFG_HOLD_MS:          hold_ms_reg <= cfg_data;
                pgt_pkg::CFG_COOLDOWN_MS:      cooldown_ms_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[InW-1:0];
        if (advance)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= pgt_pkg::MODE_SEEK;
            last_stage_reg    <= pgt_pkg::STAGE_AWAKE;
            average_reg       <= '0;
            average_valid_reg <= 1'b0;
            present_reg       <= 1'b0;
            level_reg         <= 2'd1;
            ever_seen_reg     <= 1'b0;
            lost_since_reg    <= '0;
            now_ms_reg        <= '0;
            quiet_until_reg   <= '0;
            for (int i = 0; i < GESTURE_SLOTS; i++)
            begin
                last_tumble_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            last_stage_reg    <= stage_eff;
            average_reg       <= average_next;
            average_valid_reg <= average_valid_next;
            present_reg       <= present_next;
            level_reg         <= level_next;
            ever_seen_reg     <= ever_seen_next;
            lost_since_reg    <= lost_since_next;
            now_ms_reg        <= now_ms_next;
            quiet_until_reg   <= quiet_until_next;
            if (take)
                last_tumble_reg[slot_idx] <= now_ms_next;
        end
    end

    // the input stage never blocks while empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // every evaluated frame shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("evaluated frame produced no result");

    a_tumble_kicks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[9:6] != 4'd0) |-> m_tdata[14])
        else $error("accepted gesture without activity kick");

    a_greet_dance: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[2] && (m_tdata[1:0] == pgt_pkg::MODE_DANCE))
        else $error("greeting without presence in dance mode");

    a_goodbye_absent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> !m_tdata[2] && (m_tdata[1:0] != pgt_pkg::MODE_DANCE))
        else $error("goodbye while present or still dancing");

endmodule

`default_nettype wire
